FILE: design/floppy_sector_command_builder_top_assert.svh
// Assertion macros shared by the sector command builder RTL.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef FLOPPY_SECTOR_COMMAND_BUILDER_TOP_ASSERT_SVH
`define FLOPPY_SECTOR_COMMAND_BUILDER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define FSCB_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`define FSCB_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define FSCB_ASSERT(lbl, cond, msg)

`define FSCB_ASSERT_IMPL(lbl, ante, cons, msg)

`endif

`endif

FILE: design/fscb_pkg.sv
package fscb_pkg;

    // Field widths
    localparam int BLOCK_W  = 15;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;

    // Register indexes on the configuration port
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_DRIVE_SELECT      = 3'd0;
    localparam cfg_idx_t CFG_CYLINDER_COUNT    = 3'd1;
    localparam cfg_idx_t CFG_TRACK_SECTORS     = 3'd2;
    localparam cfg_idx_t CFG_GAP_LENGTH        = 3'd3;
    localparam cfg_idx_t CFG_RATE_CODE         = 3'd4;
    localparam cfg_idx_t CFG_READ_OPCODE       = 3'd5;
    localparam cfg_idx_t CFG_WRITE_OPCODE      = 3'd6;

    // Register reset values
    localparam logic [1:0] RST_DRIVE_SELECT      = 2'd0;
    localparam logic [7:0] RST_CYLINDER_COUNT    = 8'd80;
    localparam logic [5:0] RST_TRACK_SECTORS     = 6'd18;
    localparam logic [7:0] RST_GAP_LENGTH        = 8'd27;
    localparam logic [1:0] RST_RATE_CODE         = 2'd0;
    localparam logic [7:0] RST_READ_OPCODE       = 8'd230;
    localparam logic [7:0] RST_WRITE_OPCODE      = 8'd197;

    // Fixed command bytes
    localparam logic [7:0] SIZE_CODE_BYTE = 8'h02;
    localparam logic [7:0] DTL_BYTE       = 8'hFF;

    // Block divider: three quotient bits per step
    localparam int DIV_BITS  = 3;
    localparam int DIV_STEPS = BLOCK_W / DIV_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Front-to-back job queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Output byte slots of one request
    typedef logic [3:0] slot_t;
    localparam slot_t SLOT_RATE    = 4'd0;
    localparam slot_t SLOT_OPCODE  = 4'd1;
    localparam slot_t SLOT_HD_DRV  = 4'd2;
    localparam slot_t SLOT_CYL     = 4'd3;
    localparam slot_t SLOT_HEAD    = 4'd4;
    localparam slot_t SLOT_SECTOR  = 4'd5;
    localparam slot_t SLOT_SIZE    = 4'd6;
    localparam slot_t SLOT_EOT     = 4'd7;
    localparam slot_t SLOT_GAP     = 4'd8;
    localparam slot_t SLOT_DTL     = 4'd9;

    // Output port codes
    localparam logic PORT_RATE = 1'b0;
    localparam logic PORT_FIFO = 1'b1;

    // Front end states
    typedef enum logic [1:0] {
        FR_IDLE,
        FR_CHECK,
        FR_DIV,
        FR_PUSH
    } front_state_t;

    // Configuration register set
    typedef struct packed {
        logic [1:0] drive_select;
        logic [7:0] cylinder_count;
        logic [5:0] track_sectors;
        logic [7:0] gap_length;
        logic [1:0] rate_code;
        logic [7:0] read_opcode;
        logic [7:0] write_opcode;
    } cfg_t;

    // Classified request handed from front to back
    typedef struct packed {
        logic       rejected;
        logic       is_write;
        logic [7:0] cyl;
        logic       head;
        logic [5:0] sector;
    } job_t;

endpackage

FILE: design/fscb_front.sv
module fscb_front #(
    parameter int HEAD_COUNT = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fscb_pkg::cfg_t               cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         command,
    input  logic [fscb_pkg::BLOCK_W-1:0] block_number,
    input  logic                         q_full,
    output logic                         push,
    output fscb_pkg::job_t               push_job
);

    localparam int PROD_W  = 14;
    localparam int UNITS_W = PROD_W + $clog2(HEAD_COUNT + 1);

    fscb_pkg::front_state_t state_reg, state_next;
    logic                          is_write_reg, is_write_next;
    logic                          rejected_reg, rejected_next;
    logic [fscb_pkg::BLOCK_W-1:0]  dividend_reg, dividend_next;
    logic [fscb_pkg::BLOCK_W-1:0]  quot_reg, quot_next;
    logic [5:0]                    rem_reg, rem_next;
    logic [fscb_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [PROD_W-1:0]             prod_reg, prod_next;

    logic                          accept;
    logic [UNITS_W-1:0]            units;
    logic [fscb_pkg::BLOCK_W-1:0]  div_d, div_q;
    logic [5:0]                    div_r;

    // Medium size; the constant head factor is applied after the registered product
    assign units = UNITS_W'(prod_reg) * UNITS_W'(HEAD_COUNT);

    // One divider step: three restoring compare-subtract stages
    always_comb
    begin
        logic [6:0] t;
        div_d = dividend_reg;
        div_q = quot_reg;
        div_r = rem_reg;
        for (int i = 0; i < fscb_pkg::DIV_BITS; i++)
        begin
            t = {div_r, div_d[fscb_pkg::BLOCK_W-1]};
            div_d = {div_d[fscb_pkg::BLOCK_W-2:0], 1'b0};
            if (t >= {1'b0, cfg.track_sectors})
            begin
                div_r = 6'(t - {1'b0, cfg.track_sectors});
                div_q = {div_q[fscb_pkg::BLOCK_W-2:0], 1'b1};
            end
            else
            begin
                div_r = t[5:0];
                div_q = {div_q[fscb_pkg::BLOCK_W-2:0], 1'b0};
            end
        end
    end

    // Job built from the finished division
    always_comb
    begin
        push_job = '0;
        if (rejected_reg)
        begin
            push_job.rejected = 1'b1;
        end
        else
        begin
            push_job.is_write = is_write_reg;
            push_job.cyl      = 8'(quot_reg / HEAD_COUNT);
            push_job.head     = 1'(quot_reg % HEAD_COUNT);
            push_job.sector   = 6'(rem_reg + 6'd1);
        end
    end

    // State register and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fscb_pkg::FR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_write_reg <= is_write_next;
        rejected_reg <= rejected_next;
        dividend_reg <= dividend_next;
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
        step_reg     <= step_next;
        prod_reg     <= prod_next;
    end

    // Next state and handshake
    always_comb
    begin
        state_next    = state_reg;
        is_write_next = is_write_reg;
        rejected_next = rejected_reg;
        dividend_next = dividend_reg;
        quot_next     = quot_reg;
        rem_next      = rem_reg;
        step_next     = step_reg;
        prod_next     = prod_reg;
        in_ready      = 1'b0;
        push          = 1'b0;

        case (state_reg)
            fscb_pkg::FR_IDLE:
            begin
                in_ready = 1'b1;
            end
            fscb_pkg::FR_CHECK:
            begin
                rem_next  = '0;
                quot_next = '0;
                step_next = '0;
                if (UNITS_W'(dividend_reg) >= units)
                begin
                    rejected_next = 1'b1;
                    state_next    = fscb_pkg::FR_PUSH;
                end
                else
                begin
                    rejected_next = 1'b0;
                    state_next    = fscb_pkg::FR_DIV;
                end
            end
            fscb_pkg::FR_DIV:
            begin
                dividend_next = div_d;
                quot_next     = div_q;
                rem_next      = div_r;
                step_next     = step_reg + 1'b1;
                if (step_reg == fscb_pkg::STEP_W'(fscb_pkg::DIV_STEPS - 1))
                begin
                    state_next = fscb_pkg::FR_PUSH;
                end
            end
            fscb_pkg::FR_PUSH:
            begin
                if (!q_full)
                begin
                    push       = 1'b1;
                    in_ready   = 1'b1;
                    state_next = fscb_pkg::FR_IDLE;
                end
            end
            default:
            begin
                state_next = fscb_pkg::FR_IDLE;
            end
        endcase

        // Latch a new request; its range check runs next cycle
        accept = in_valid && in_ready;
        if (accept)
        begin
            is_write_next = command;
            dividend_next = block_number;
            prod_next     = PROD_W'(cfg.cylinder_count) * PROD_W'(cfg.track_sectors);
            state_next    = fscb_pkg::FR_CHECK;
        end
    end

endmodule

FILE: design/fscb_queue.sv
module fscb_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  fscb_pkg::job_t push_job,
    input  logic           pop,
    output fscb_pkg::job_t head_job,
    output logic           full,
    output logic           empty
);

    fscb_pkg::job_t                entries_reg [fscb_pkg::Q_DEPTH];
    logic [fscb_pkg::Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [fscb_pkg::Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [fscb_pkg::Q_CNT_W-1:0]  count_reg, count_next;

    assign full     = (count_reg == fscb_pkg::Q_CNT_W'(fscb_pkg::Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = entries_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == fscb_pkg::Q_PTR_W'(fscb_pkg::Q_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == fscb_pkg::Q_PTR_W'(fscb_pkg::Q_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: design/fscb_back.sv
`include "floppy_sector_command_builder_top_assert.svh"

module fscb_back (
    input  logic           clk,
    input  logic           rst_n,
    input  fscb_pkg::cfg_t cfg,
    input  fscb_pkg::job_t job,
    input  logic           job_valid,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           port,
    output logic [7:0]     data_byte,
    output logic           last,
    output logic           rejected
);

    fscb_pkg::slot_t slot_reg, slot_next;
    logic            out_valid_reg, out_valid_next;
    logic            port_reg, port_next;
    logic [7:0]      data_reg, data_next;
    logic            last_reg, last_next;
    logic            rej_reg, rej_next;
    logic            load;

    // Output register takes a byte when empty or being drained
    assign load = job_valid && (!out_valid_reg || out_ready);

    // Byte sequencer for the queue head
    always_comb
    begin
        slot_next      = slot_reg;
        out_valid_next = out_valid_reg;
        port_next      = port_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        rej_next       = rej_reg;
        pop            = 1'b0;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (load)
        begin
            out_valid_next = 1'b1;
            port_next      = fscb_pkg::PORT_FIFO;
            last_next      = 1'b0;
            rej_next       = 1'b0;
            case (slot_reg)
                fscb_pkg::SLOT_RATE:
                begin
                    port_next = fscb_pkg::PORT_RATE;
                    data_next = {6'b0, cfg.rate_code};
                end
                fscb_pkg::SLOT_OPCODE:
                    data_next = job.is_write ? cfg.write_opcode : cfg.read_opcode;
                fscb_pkg::SLOT_HD_DRV:
                    data_next = {5'b0, job.head, cfg.drive_select};
                fscb_pkg::SLOT_CYL:
                    data_next = job.cyl;
                fscb_pkg::SLOT_HEAD:
                    data_next = {7'b0, job.head};
                fscb_pkg::SLOT_SECTOR:
                    data_next = {2'b0, job.sector};
                fscb_pkg::SLOT_SIZE:
                    data_next = fscb_pkg::SIZE_CODE_BYTE;
                fscb_pkg::SLOT_EOT:
                    data_next = {2'b0, cfg.track_sectors};
                fscb_pkg::SLOT_GAP:
                    data_next = cfg.gap_length;
                fscb_pkg::SLOT_DTL:
                begin
                    data_next = fscb_pkg::DTL_BYTE;
                    last_next = 1'b1;
                end
                default:
                    data_next = '0;
            endcase

            // Out-of-range request: single rejected byte
            if (job.rejected)
            begin
                port_next = fscb_pkg::PORT_RATE;
                data_next = '0;
                last_next = 1'b1;
                rej_next  = 1'b1;
            end

            if (last_next)
            begin
                pop       = 1'b1;
                slot_next = fscb_pkg::SLOT_RATE;
            end
            else
            begin
                slot_next = slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= fscb_pkg::SLOT_RATE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        port_reg <= port_next;
        data_reg <= data_next;
        last_reg <= last_next;
        rej_reg  <= rej_next;
    end

    assign out_valid = out_valid_reg;
    assign port      = port_reg;
    assign data_byte = data_reg;
    assign last      = last_reg;
    assign rejected  = rej_reg;

    // Checks
    `FSCB_ASSERT_IMPL(a_pop_with_load, pop, load && last_next, "queue popped without final byte")
    `FSCB_ASSERT_IMPL(a_rej_single, out_valid_reg && rej_reg, last_reg && (port_reg == fscb_pkg::PORT_RATE) && (data_reg == 8'h00), "rejected byte malformed")
    `FSCB_ASSERT(a_slot_range, slot_reg <= fscb_pkg::SLOT_DTL, "byte slot out of range")
    `FSCB_ASSERT_IMPL(a_slot_restart, pop, slot_next == fscb_pkg::SLOT_RATE, "slot not reset after request")

endmodule

FILE: design/floppy_sector_command_builder_top.sv
// Channel   Handshake            Payload
// in        in_valid / in_ready  command, block_number
// out       out_valid/out_ready  port, data_byte, last, rejected
// cfg       cfg_write            cfg_index, cfg_data
//
// An in-range request gives ten bytes at one per cycle while out_ready stays high;
// a steady stream is paced by the back sequencer's byte slots, not by the front.
// Front: accept, FR_CHECK range check, 5-step FR_DIV block divider, FR_PUSH; one
// request at a time, overlapped with the back through a 2-entry job queue.
// A rejected request skips FR_DIV and gives 1 output byte.
// Reset is asynchronous; no clearing pass. A stalled output holds both queue and front.
module floppy_sector_command_builder_top #(
    parameter int HEAD_COUNT = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [fscb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fscb_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            command,
    input  logic [fscb_pkg::BLOCK_W-1:0]    block_number,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            port,
    output logic [7:0]                      data_byte,
    output logic                            last,
    output logic                            rejected
);

    fscb_pkg::cfg_t cfg_reg, cfg_next;
    fscb_pkg::job_t push_job, head_job;
    logic           push, pop, q_full, q_empty;

    // Configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                fscb_pkg::CFG_DRIVE_SELECT:      cfg_next.drive_select      = cfg_data[1:0];
                fscb_pkg::CFG_CYLINDER_COUNT:    cfg_next.cylinder_count    = cfg_data;
                fscb_pkg::CFG_TRACK_SECTORS:     cfg_next.track_sectors     = cfg_data[5:0];
                fscb_pkg::CFG_GAP_LENGTH:        cfg_next.gap_length        = cfg_data;
                fscb_pkg::CFG_RATE_CODE:         cfg_next.rate_code         = cfg_data[1:0];
                fscb_pkg::CFG_READ_OPCODE:       cfg_next.read_opcode       = cfg_data;
                fscb_pkg::CFG_WRITE_OPCODE:      cfg_next.write_opcode      = cfg_data;
                default:                         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drive_select      <= fscb_pkg::RST_DRIVE_SELECT;
            cfg_reg.cylinder_count    <= fscb_pkg::RST_CYLINDER_COUNT;
            cfg_reg.track_sectors     <= fscb_pkg::RST_TRACK_SECTORS;
            cfg_reg.gap_length        <= fscb_pkg::RST_GAP_LENGTH;
            cfg_reg.rate_code         <= fscb_pkg::RST_RATE_CODE;
            cfg_reg.read_opcode       <= fscb_pkg::RST_READ_OPCODE;
            cfg_reg.write_opcode      <= fscb_pkg::RST_WRITE_OPCODE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: accept, range check, block divide
    fscb_front #(
        .HEAD_COUNT (HEAD_COUNT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .block_number (block_number),
        .q_full       (q_full),
        .push         (push),
        .push_job     (push_job)
    );

    // Job queue between front and back
    fscb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Back: byte sequencer and output register
    fscb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job       (head_job),
        .job_valid (!q_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .port      (port),
        .data_byte (data_byte),
        .last      (last),
        .rejected  (rejected)
    );

endmodule

FILE: tb/floppy_sector_command_checker.sv
`timescale 1ns / 1ps

// Watches the request and byte channels, predicts the command bytes of every
// accepted request, and compares them in order with what the block sends.
module floppy_sector_command_checker #(
    parameter int HEAD_COUNT = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [fscb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fscb_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            command,
    input  logic [fscb_pkg::BLOCK_W-1:0]    block_number,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            port,
    input  logic [7:0]                      data_byte,
    input  logic                            last,
    input  logic                            rejected,
    output int                              mismatch_count,
    output int                              bytes_pending
);
    import fscb_pkg::*;

    typedef struct packed {
        logic       port;
        logic [7:0] data_byte;
        logic       last;
        logic       rejected;
    } fdc_byte_t;

    // Bytes still owed by the block, oldest first
    fdc_byte_t expected_bytes[$];
    fdc_byte_t want;
    fdc_byte_t got;

    // Shadow copy of the register set
    logic [1:0] drive_sel;
    logic [7:0] cyl_count;
    logic [5:0] spt;
    logic [7:0] gap_len;
    logic [1:0] rate_sel;
    logic [7:0] rd_opcode;
    logic [7:0] wr_opcode;

    function automatic fdc_byte_t fdc_byte(logic dest, logic [7:0] value, logic is_last,
                                           logic is_rej);
        fdc_byte_t b;
        b.port      = dest;
        b.data_byte = value;
        b.last      = is_last;
        b.rejected  = is_rej;
        return b;
    endfunction

    // Range check, block to CHS split, then the ten command bytes or one rejected byte
    task automatic queue_sector_command(input logic is_write, input logic [BLOCK_W-1:0] blk);
        int unsigned medium_size;
        int unsigned track;
        int unsigned sector;
        int unsigned head;
        int unsigned cyl;
        logic [7:0]  opcode;
        medium_size = int'(cyl_count) * HEAD_COUNT * int'(spt);
        if (int'(blk) >= medium_size)
        begin
            expected_bytes.push_back(fdc_byte(PORT_RATE, 8'h00, 1'b1, 1'b1));
        end
        else
        begin
            track  = int'(blk) / int'(spt);
            sector = int'(blk) % int'(spt) + 1;
            head   = track % HEAD_COUNT;
            cyl    = track / HEAD_COUNT;
            opcode = is_write ? wr_opcode : rd_opcode;
            expected_bytes.push_back(fdc_byte(PORT_RATE, 8'(rate_sel), 1'b0, 1'b0));
            expected_bytes.push_back(fdc_byte(PORT_FIFO, opcode, 1'b0, 1'b0));
            expected_bytes.push_back(fdc_byte(PORT_FIFO, 8'((head << 2) | drive_sel), 1'b0, 1'b0));
            expected_bytes.push_back(fdc_byte(PORT_FIFO, 8'(cyl), 1'b0, 1'b0));
            expected_bytes.push_back(fdc_byte(PORT_FIFO, 8'(head), 1'b0, 1'b0));
            expected_bytes.push_back(fdc_byte(PORT_FIFO, 8'(sector), 1'b0, 1'b0));
            expected_bytes.push_back(fdc_byte(PORT_FIFO, SIZE_CODE_BYTE, 1'b0, 1'b0));
            expected_bytes.push_back(fdc_byte(PORT_FIFO, 8'(spt), 1'b0, 1'b0));
            expected_bytes.push_back(fdc_byte(PORT_FIFO, gap_len, 1'b0, 1'b0));
            expected_bytes.push_back(fdc_byte(PORT_FIFO, DTL_BYTE, 1'b1, 1'b0));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_sel = RST_DRIVE_SELECT;
            cyl_count = RST_CYLINDER_COUNT;
            spt       = RST_TRACK_SECTORS;
            gap_len   = RST_GAP_LENGTH;
            rate_sel  = RST_RATE_CODE;
            rd_opcode = RST_READ_OPCODE;
            wr_opcode = RST_WRITE_OPCODE;
            expected_bytes.delete();
            mismatch_count = 0;
            bytes_pending  = 0;
        end
        else
        begin
            // Register writes, masked to width; unknown indexes are dropped
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_DRIVE_SELECT:      drive_sel = cfg_data[1:0];
                    CFG_CYLINDER_COUNT:    cyl_count = cfg_data[7:0];
                    CFG_TRACK_SECTORS:     spt       = cfg_data[5:0];
                    CFG_GAP_LENGTH:        gap_len   = cfg_data[7:0];
                    CFG_RATE_CODE:         rate_sel  = cfg_data[1:0];
                    CFG_READ_OPCODE:       rd_opcode = cfg_data[7:0];
                    CFG_WRITE_OPCODE:      wr_opcode = cfg_data[7:0];
                    default: ;
                endcase
            end

            // Output byte against the oldest expectation
            if (out_valid && out_ready)
            begin
                got = fdc_byte(port, data_byte, last, rejected);
                if (expected_bytes.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("%0t: unexpected byte port=%0b data=%02h last=%0b rej=%0b",
                                 $realtime, got.port, got.data_byte, got.last, got.rejected);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (got !== want)
                    begin
                        if (mismatch_count < 10)
                            $display({"%0t: byte mismatch exp port=%0b data=%02h last=%0b ",
                                      "rej=%0b got port=%0b data=%02h last=%0b rej=%0b"},
                                     $realtime, want.port, want.data_byte, want.last,
                                     want.rejected, got.port, got.data_byte, got.last,
                                     got.rejected);
                        mismatch_count++;
                    end
                end
            end

            if (in_valid && in_ready)
                queue_sector_command(command, block_number);

            bytes_pending = expected_bytes.size();
        end
    end

endmodule

FILE: tb/floppy_sector_command_builder_top_tb.sv
`timescale 1ns / 1ps

module floppy_sector_command_builder_top_tb;
    import fscb_pkg::*;

    localparam int HEAD_COUNT    = 2;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 32;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 30;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Index past the end of the register list
    localparam cfg_idx_t CFG_UNUSED_INDEX = 3'd7;

    typedef enum {
        READY_ALWAYS,
        READY_COIN,
        READY_ONE_IN_FOUR,
        READY_WINDOWED
    } ready_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  command = 1'b0;
    logic [BLOCK_W-1:0]    block_number = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  port;
    logic [7:0]            data_byte;
    logic                  last;
    logic                  rejected;

    int mismatch_count;
    int bytes_pending;
    int cycle_count = 0;
    int burst_left = 0;

    // Geometry as last written, for picking in-range blocks
    int geo_cyl = RST_CYLINDER_COUNT;
    int geo_spt = RST_TRACK_SECTORS;

    ready_mode_t ready_mode = READY_ALWAYS;
    int          mode_left = 0;
    int          ready_phase = 0;

    floppy_sector_command_builder_top #(
        .HEAD_COUNT(HEAD_COUNT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .block_number(block_number),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .port(port),
        .data_byte(data_byte),
        .last(last),
        .rejected(rejected)
    );

    floppy_sector_command_checker #(
        .HEAD_COUNT(HEAD_COUNT)
    ) sector_chk (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .block_number(block_number),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .port(port),
        .data_byte(data_byte),
        .last(last),
        .rejected(rejected),
        .mismatch_count(mismatch_count),
        .bytes_pending(bytes_pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("floppy_sector_command_builder_top test failed");
            $finish;
        end
    end

    // Byte sink: ready pattern is redrawn whenever its run counter expires
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(40, 300);
        end
        else
            mode_left--;
        ready_phase++;
        case (ready_mode)
            READY_ALWAYS:      out_ready <= 1'b1;
            READY_COIN:        out_ready <= ($urandom_range(0, 1) == 1);
            READY_ONE_IN_FOUR: out_ready <= (ready_phase % 4 == 0);
            default:           out_ready <= (ready_phase % 11 >= 6);
        endcase
    end

    task automatic write_register(input cfg_idx_t idx, input logic [7:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (idx == CFG_CYLINDER_COUNT)
            geo_cyl = value;
        else if (idx == CFG_TRACK_SECTORS)
            geo_spt = value[5:0];
    endtask

    // One request; valid stays up through a burst, drops for a random gap after it
    task automatic send_request(input logic cmd, input logic [BLOCK_W-1:0] blk);
        in_valid     <= 1'b1;
        command      <= cmd;
        block_number <= blk;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(0, 20);
        end
        else
            burst_left--;
    endtask

    // Hold off new requests until every byte is out and the front end is quiet
    task automatic drain_requests();
        in_valid <= 1'b0;
        @(posedge clk);
        while (bytes_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly in-range blocks, with the disk boundary and raw noise mixed in
    function automatic logic [BLOCK_W-1:0] pick_block();
        int disk_size;
        disk_size = geo_cyl * HEAD_COUNT * geo_spt;
        if (disk_size == 0)
            return BLOCK_W'($urandom);
        case ($urandom_range(0, 9))
            0:       return BLOCK_W'($urandom);
            1:       return (disk_size < 32768) ? BLOCK_W'(disk_size) : BLOCK_W'($urandom);
            2:       return BLOCK_W'(disk_size - 1);
            default: return BLOCK_W'($urandom_range(0, disk_size - 1));
        endcase
    endfunction

    function automatic int pick_range(int lo, int hi);
        case ($urandom_range(0, 5))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry: 80 x 2 x 18, track and cylinder edges, boundary, all-ones
        send_request(CMD_READ, 15'd0);
        send_request(CMD_WRITE, 15'd0);
        send_request(CMD_READ, 15'd17);
        send_request(CMD_WRITE, 15'd18);
        send_request(CMD_READ, 15'd36);
        send_request(CMD_READ, 15'd2879);
        send_request(CMD_WRITE, 15'd2880);
        send_request(CMD_READ, 15'h7FFF);
        send_request(CMD_WRITE, 15'h5555);
        drain_requests();

        // Largest geometry and all-ones register data (masked on narrow ones)
        write_register(CFG_DRIVE_SELECT, 8'hFF);
        write_register(CFG_CYLINDER_COUNT, 8'd255);
        write_register(CFG_TRACK_SECTORS, 8'hFF);
        write_register(CFG_GAP_LENGTH, 8'hFF);
        write_register(CFG_RATE_CODE, 8'hFF);
        write_register(CFG_READ_OPCODE, 8'h00);
        write_register(CFG_WRITE_OPCODE, 8'hFF);
        send_request(CMD_READ, 15'd32129);
        send_request(CMD_WRITE, 15'd32130);
        send_request(CMD_READ, 15'h2AAA);
        send_request(CMD_WRITE, 15'h5555);
        send_request(CMD_WRITE, 15'd0);
        drain_requests();

        // Smallest nonzero geometry; a write to an unused index must change nothing
        write_register(CFG_DRIVE_SELECT, 8'h00);
        write_register(CFG_CYLINDER_COUNT, 8'd1);
        write_register(CFG_TRACK_SECTORS, 8'd1);
        write_register(CFG_GAP_LENGTH, 8'h00);
        write_register(CFG_RATE_CODE, 8'h00);
        write_register(CFG_READ_OPCODE, 8'hFF);
        write_register(CFG_WRITE_OPCODE, 8'h00);
        write_register(CFG_UNUSED_INDEX, 8'h55);
        send_request(CMD_READ, 15'd0);
        send_request(CMD_WRITE, 15'd1);
        send_request(CMD_READ, 15'd2);
        drain_requests();

        // Zero geometry rejects everything
        write_register(CFG_CYLINDER_COUNT, 8'd0);
        send_request(CMD_READ, 15'd0);
        drain_requests();
        write_register(CFG_CYLINDER_COUNT, 8'd1);
        write_register(CFG_TRACK_SECTORS, 8'd0);
        send_request(CMD_WRITE, 15'd0);
        drain_requests();

        // Random phases, each with a fresh register set
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            write_register(CFG_DRIVE_SELECT, 8'($urandom));
            write_register(CFG_CYLINDER_COUNT, 8'(pick_range(1, 255)));
            write_register(CFG_TRACK_SECTORS, {2'($urandom), 6'(pick_range(1, 63))});
            write_register(CFG_GAP_LENGTH, 8'(pick_range(0, 255)));
            write_register(CFG_RATE_CODE, 8'($urandom));
            write_register(CFG_READ_OPCODE, 8'(pick_range(0, 255)));
            write_register(CFG_WRITE_OPCODE, 8'(pick_range(0, 255)));
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(1'($urandom_range(0, 1)), pick_block());
            drain_requests();
        end

        // Final drain, then a quiet window for stray bytes
        in_valid <= 1'b0;
        @(posedge clk);
        while (bytes_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("floppy_sector_command_builder_top test passed");
        else
            $display("floppy_sector_command_builder_top test failed");
        $finish;
    end

endmodule
